[hdl/cbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, codes and the sequencer microprogram of the bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int unsigned STEP_W = 5;
	localparam int unsigned DIV_W  = 9;

	// remainder unit iterations, one dividend bit per cycle
	localparam logic [3:0] DIV_BITS = 4'd9;

	// result kinds
	localparam logic [1:0] KIND_PROG   = 2'd0;
	localparam logic [1:0] KIND_CHAR   = 2'd1;
	localparam logic [1:0] KIND_MIRROR = 2'd2;

	// bus decode
	localparam logic [7:0] ADDR_SELECT = 8'h00;
	localparam logic [7:0] ADDR_DATA   = 8'h01;

	// bank registers with a fixed role
	localparam logic [2:0] REG_PROG   = 3'd5;
	localparam logic [2:0] REG_MIRROR = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_PROG_COUNT  = 2'd0;
	localparam logic [1:0] CFG_CHAR_COUNT  = 2'd1;
	localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;

	typedef enum logic [1:0] {
		OP_JUMP,
		OP_DIV,
		OP_EMIT,
		OP_DONE
	} op_t;

	typedef enum logic [1:0] {
		COND_PROG_ZERO,
		COND_CHAR_ZERO,
		COND_FOUR_SCREEN
	} cond_t;

	typedef enum logic [1:0] {
		SRC_REM,
		SRC_REM_INC,
		SRC_PROG_LAST,
		SRC_MIRROR
	} src_t;

	typedef enum logic {
		DVD_REG_PROG,
		DVD_REG_X2
	} dvd_t;

	typedef enum logic [1:0] {
		LAST_NEVER,
		LAST_AFTER_PROG,
		LAST_AFTER_CHAR,
		LAST_ALWAYS
	} last_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
		dvd_t              dvd;
		logic [1:0]        reg_idx;
		logic              use_char;
		logic [1:0]        kind;
		logic [2:0]        slot;
		src_t              src;
		last_t             last;
	} ucode_t;

	// microprogram: program group, character group, mirroring
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '{op: OP_DONE, cond: COND_PROG_ZERO, target: '0, dvd: DVD_REG_PROG,
			reg_idx: 2'd0, use_char: 1'b0, kind: KIND_PROG, slot: 3'd0,
			src: SRC_REM, last: LAST_NEVER};
		case (step)
			5'd0: begin
				w.op = OP_JUMP; w.cond = COND_PROG_ZERO; w.target = 5'd6;
			end
			5'd1: begin
				w.op = OP_DIV; w.dvd = DVD_REG_PROG; w.use_char = 1'b0;
			end
			5'd2: begin
				w.op = OP_EMIT; w.kind = KIND_PROG; w.slot = 3'd0; w.src = SRC_REM;
			end
			5'd3: begin
				w.op = OP_EMIT; w.kind = KIND_PROG; w.slot = 3'd1; w.src = SRC_REM;
			end
			5'd4: begin
				w.op = OP_EMIT; w.kind = KIND_PROG; w.slot = 3'd2; w.src = SRC_PROG_LAST;
			end
			5'd5: begin
				w.op = OP_EMIT; w.kind = KIND_PROG; w.slot = 3'd3; w.src = SRC_PROG_LAST;
				w.last = LAST_AFTER_PROG;
			end
			5'd6: begin
				w.op = OP_JUMP; w.cond = COND_CHAR_ZERO; w.target = 5'd19;
			end
			5'd7: begin
				w.op = OP_DIV; w.dvd = DVD_REG_X2; w.reg_idx = 2'd0; w.use_char = 1'b1;
			end
			5'd8: begin
				w.op = OP_EMIT; w.kind = KIND_CHAR; w.slot = 3'd0; w.src = SRC_REM;
			end
			5'd9: begin
				w.op = OP_EMIT; w.kind = KIND_CHAR; w.slot = 3'd1; w.src = SRC_REM_INC;
			end
			5'd10: begin
				w.op = OP_DIV; w.dvd = DVD_REG_X2; w.reg_idx = 2'd1; w.use_char = 1'b1;
			end
			5'd11: begin
				w.op = OP_EMIT; w.kind = KIND_CHAR; w.slot = 3'd2; w.src = SRC_REM;
			end
			5'd12: begin
				w.op = OP_EMIT; w.kind = KIND_CHAR; w.slot = 3'd3; w.src = SRC_REM_INC;
			end
			5'd13: begin
				w.op = OP_DIV; w.dvd = DVD_REG_X2; w.reg_idx = 2'd2; w.use_char = 1'b1;
			end
			5'd14: begin
				w.op = OP_EMIT; w.kind = KIND_CHAR; w.slot = 3'd4; w.src = SRC_REM;
			end
			5'd15: begin
				w.op = OP_EMIT; w.kind = KIND_CHAR; w.slot = 3'd5; w.src = SRC_REM_INC;
			end
			5'd16: begin
				w.op = OP_DIV; w.dvd = DVD_REG_X2; w.reg_idx = 2'd3; w.use_char = 1'b1;
			end
			5'd17: begin
				w.op = OP_EMIT; w.kind = KIND_CHAR; w.slot = 3'd6; w.src = SRC_REM;
			end
			5'd18: begin
				w.op = OP_EMIT; w.kind = KIND_CHAR; w.slot = 3'd7; w.src = SRC_REM_INC;
				w.last = LAST_AFTER_CHAR;
			end
			5'd19: begin
				w.op = OP_JUMP; w.cond = COND_FOUR_SCREEN; w.target = 5'd21;
			end
			5'd20: begin
				w.op = OP_EMIT; w.kind = KIND_MIRROR; w.slot = 3'd0; w.src = SRC_MIRROR;
				w.last = LAST_ALWAYS;
			end
			default: begin
				w.op = OP_DONE;
			end
		endcase
		return w;
	endfunction

endpackage

[hdl/cartridge_bank_mapper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Bus-write driven bank switch that replays the full slot map after updates.
// ----------------------------------------------------------------------------
// usage:
//   command channel: a transaction is taken on a rising edge with start high
//   and busy low. mode 1 clears the eight bank registers and the select and
//   replays the map. mode 0 is a bus write: low address byte 0 latches the
//   register select (no results, busy never rises), byte 1 writes the
//   selected register and replays the map, any other byte is ignored.
//   result channel: each result shows for one cycle with result_valid high;
//   last marks the final result of a replay. the receiver cannot stall.
//   config channel: cfg_valid/cfg_ready with cfg_index 0 program bank count,
//   1 character bank count, 2 four-screen; other indexes are dropped.
//   cfg_ready is low while a replay runs.
// operation:
//   a replay is sequenced by a microprogram over a bit-serial remainder unit.
//   a select write is taken without raising busy. one transaction at a time.
// reset: arst_n clears counts, bank registers, select and the sequencer.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper
	import cbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	// result channel
	output logic        result_valid,
	output logic [1:0]  kind,
	output logic [2:0]  slot,
	output logic [7:0]  bank,
	output logic        last,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// configuration
	logic [7:0] prog_count_q;
	logic [7:0] char_count_q;
	logic       four_screen_q;

	// mapper state
	logic [7:0] bank_regs_q [8];
	logic [2:0] select_q;

	// sequencer
	logic              busy_q;
	logic [STEP_W-1:0] pc_q;
	ucode_t            uw;

	// remainder unit
	logic             div_run_q;
	logic [3:0]       div_cnt_q;
	logic [DIV_W-1:0] dvd_q;
	logic [7:0]       rem_q;
	logic [7:0]       divisor_q;
	logic [DIV_W-1:0] div_trial;
	logic             div_fit;
	logic [7:0]       rem_next;
	logic [DIV_W-1:0] dvd_load;

	// result register
	logic       result_valid_q;
	logic [1:0] kind_q;
	logic [2:0] slot_q;
	logic [7:0] bank_q;
	logic       last_q;

	logic       accept;
	logic       cfg_write;
	logic       is_data_write;
	logic       run_map;
	logic       cond_hit;
	logic       last_hit;
	logic [7:0] emit_bank;
	logic [8:0] rem_inc;

	assign accept        = start && !busy_q;
	assign cfg_write     = cfg_valid && cfg_ready;
	assign is_data_write = !mode && (address[7:0] == ADDR_DATA);
	assign run_map       = accept && (mode || is_data_write);
	assign uw            = ucode_rom(pc_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_count_q  <= '0;
			char_count_q  <= '0;
			four_screen_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PROG_COUNT:  prog_count_q  <= cfg_data;
				CFG_CHAR_COUNT:  char_count_q  <= cfg_data;
				CFG_FOUR_SCREEN: four_screen_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// bank registers and select, updated when the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) bank_regs_q[i] <= '0;
			select_q <= '0;
		end else if (accept) begin
			if (mode) begin
				for (int i = 0; i < 8; i++) bank_regs_q[i] <= '0;
				select_q <= '0;
			end else if (address[7:0] == ADDR_SELECT) begin
				select_q <= data[2:0];
			end else if (address[7:0] == ADDR_DATA) begin
				bank_regs_q[select_q] <= data;
			end
		end
	end

	// jump conditions of the microprogram
	always_comb begin
		case (uw.cond)
			COND_PROG_ZERO:   cond_hit = (prog_count_q == 8'd0);
			COND_CHAR_ZERO:   cond_hit = (char_count_q == 8'd0);
			COND_FOUR_SCREEN: cond_hit = four_screen_q;
			default:          cond_hit = 1'b0;
		endcase
	end

	// does anything follow this result
	always_comb begin
		case (uw.last)
			LAST_AFTER_PROG: last_hit = (char_count_q == 8'd0) && four_screen_q;
			LAST_AFTER_CHAR: last_hit = four_screen_q;
			LAST_ALWAYS:     last_hit = 1'b1;
			default:         last_hit = 1'b0;
		endcase
	end

	// bank value of an emitted result; remainder is below the count,
	// so the next bank wraps with one compare
	assign rem_inc = {1'b0, rem_q} + 9'd1;
	always_comb begin
		case (uw.src)
			SRC_REM:       emit_bank = rem_q;
			SRC_REM_INC:   emit_bank = (rem_inc == {1'b0, char_count_q}) ? 8'd0 : rem_inc[7:0];
			SRC_PROG_LAST: emit_bank = prog_count_q - 8'd1;
			SRC_MIRROR:    emit_bank = {7'd0, bank_regs_q[REG_MIRROR][0]};
			default:       emit_bank = rem_q;
		endcase
	end

	// dividend for a modulo step
	always_comb begin
		case (uw.dvd)
			DVD_REG_PROG: dvd_load = {1'b0, bank_regs_q[REG_PROG]};
			DVD_REG_X2:   dvd_load = {bank_regs_q[{1'b0, uw.reg_idx}], 1'b0};
			default:      dvd_load = '0;
		endcase
	end

	// restoring remainder, one dividend bit per cycle
	assign div_trial = {rem_q, dvd_q[DIV_W-1]};
	assign div_fit   = (div_trial >= {1'b0, divisor_q});
	always_comb begin
		logic [DIV_W-1:0] diff;
		diff     = div_trial - {1'b0, divisor_q};
		rem_next = div_fit ? diff[7:0] : div_trial[7:0];
	end

	// step counter and datapath control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			pc_q           <= '0;
			div_run_q      <= 1'b0;
			div_cnt_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (run_map) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end else if (busy_q) begin
				case (uw.op)
					OP_JUMP: begin
						pc_q <= cond_hit ? uw.target : pc_q + 1'b1;
					end
					OP_DIV: begin
						if (!div_run_q) begin
							div_run_q <= 1'b1;
							div_cnt_q <= DIV_BITS;
						end else begin
							div_cnt_q <= div_cnt_q - 4'd1;
							if (div_cnt_q == 4'd1) begin
								div_run_q <= 1'b0;
								pc_q      <= pc_q + 1'b1;
							end
						end
					end
					OP_EMIT: begin
						result_valid_q <= 1'b1;
						pc_q           <= pc_q + 1'b1;
					end
					default: begin
						busy_q <= 1'b0;
					end
				endcase
			end
		end
	end

	// remainder unit payload
	always_ff @(posedge clk) begin
		if (busy_q && (uw.op == OP_DIV)) begin
			if (!div_run_q) begin
				dvd_q     <= dvd_load;
				rem_q     <= '0;
				divisor_q <= uw.use_char ? char_count_q : prog_count_q;
			end else begin
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
				rem_q <= rem_next;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (busy_q && (uw.op == OP_EMIT)) begin
			kind_q <= uw.kind;
			slot_q <= uw.slot;
			bank_q <= emit_bank;
			last_q <= last_hit;
		end
	end

	assign busy         = busy_q;
	assign cfg_ready    = !busy_q;
	assign result_valid = result_valid_q;
	assign kind         = kind_q;
	assign slot         = slot_q;
	assign bank         = bank_q;
	assign last         = last_q;

endmodule

[hdl/cbm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks of the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
module cbm_checker
	import cbm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        mode,
	input logic [15:0] address,
	input logic [7:0]  data,
	input logic        result_valid,
	input logic [1:0]  kind,
	input logic [2:0]  slot,
	input logic [7:0]  bank,
	input logic        last,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [7:0]  cfg_data
);

	// results only come out of a running replay
	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result outside a replay");

	// a select write never starts a replay
	a_select_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !mode && (address[7:0] == ADDR_SELECT)) |=> !busy)
		else $error("select write started a replay");

	// mirroring closes the run, on slot zero, with a one-bit bank
	a_mirror_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (kind == KIND_MIRROR)) |-> (last && (slot == 3'd0) && (bank[7:1] == 7'd0)))
		else $error("bad mirroring result");

	// nothing follows the last result
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !result_valid)
		else $error("result after last");

	// program slot banks stay below slot 4
	a_prog_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (kind == KIND_PROG)) |-> !slot[2])
		else $error("program slot out of range");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cartridge bank mapper. A queue of bus writes,
// initialize requests, configuration writes and drain points is built up
// front; a clocked driver plays it out with random idle bursts, a shadow of
// the mapper predicts every slot load, and a clocked monitor compares each
// strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import cbm_pkg::*;

	// command codes of the mode input
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_INIT  = 1'b1;

	// index past the last configuration register, dropped by the block
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// idle cycles allowed for a replay to wind down
	localparam int unsigned SETTLE_CYCLES = 80;

	// pending stimulus entry kinds
	typedef enum logic [1:0] {
		ITEM_BUS,
		ITEM_CFG,
		ITEM_PAUSE
	} item_kind_t;

	typedef struct packed {
		item_kind_t  what;
		logic        mode;
		logic [15:0] address;
		logic [7:0]  data;
		logic [1:0]  cfg_idx;
		logic [7:0]  cfg_val;
		logic [4:0]  gap;
	} bus_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] slot;
		logic [7:0] bank;
		logic       last;
	} slot_load_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, all known from time zero
	logic        start = 1'b0;
	logic        mode = 1'b0;
	logic [15:0] address = '0;
	logic [7:0]  data = '0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	// block outputs
	logic       busy;
	logic       result_valid;
	logic [1:0] kind;
	logic [2:0] slot;
	logic [7:0] bank;
	logic       last;
	logic       cfg_ready;

	// stimulus still to be played and slot loads still to arrive
	bus_item_t  bus_q[$];
	slot_load_t load_q[$];

	// shadow copy of the mapper state and configuration
	logic [7:0] shadow_bank[8];
	logic [2:0] shadow_sel;
	logic [7:0] prog_count;
	logic [7:0] char_count;
	logic       four_scr;

	int unsigned mismatches = 0;
	int unsigned idle_on = 1;

	cartridge_bank_mapper u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.address      (address),
		.data         (data),
		.result_valid (result_valid),
		.kind         (kind),
		.slot         (slot),
		.bank         (bank),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	function automatic void push_load(logic [1:0] k, logic [2:0] s, logic [7:0] b);
		load_q.push_back('{kind: k, slot: s, bank: b, last: 1'b0});
	endfunction

	// full map replay: program group, character group, mirroring
	function automatic int unsigned replay_map();
		int unsigned first;
		int unsigned rem;
		int unsigned i;
		slot_load_t tail;
		first = load_q.size();
		if (prog_count != 8'd0) begin
			rem = int'(shadow_bank[REG_PROG]) % int'(prog_count);
			push_load(KIND_PROG, 3'd0, rem[7:0]);
			push_load(KIND_PROG, 3'd1, rem[7:0]);
			push_load(KIND_PROG, 3'd2, prog_count - 8'd1);
			push_load(KIND_PROG, 3'd3, prog_count - 8'd1);
		end
		if (char_count != 8'd0) begin
			for (i = 0; i < 4; i++) begin
				// doubled register needs nine bits before the modulo
				rem = (int'(shadow_bank[i]) * 2) % int'(char_count);
				push_load(KIND_CHAR, 3'(i * 2), rem[7:0]);
				rem = (rem + 1) % int'(char_count);
				push_load(KIND_CHAR, 3'(i * 2 + 1), rem[7:0]);
			end
		end
		if (!four_scr)
			push_load(KIND_MIRROR, 3'd0, {7'd0, shadow_bank[REG_MIRROR][0]});
		// flag the final load of this replay
		if (load_q.size() > first) begin
			tail = load_q.pop_back();
			tail.last = 1'b1;
			load_q.push_back(tail);
		end
		return load_q.size() - first;
	endfunction

	// one accepted transaction on the command channel
	function automatic int unsigned mapper_step(bus_item_t it);
		int unsigned i;
		if (it.mode == MODE_INIT) begin
			for (i = 0; i < 8; i++)
				shadow_bank[i] = 8'd0;
			shadow_sel = 3'd0;
			return replay_map();
		end
		if (it.address[7:0] == ADDR_SELECT) begin
			// only the low three data bits pick the register
			shadow_sel = it.data[2:0];
			return 0;
		end
		if (it.address[7:0] == ADDR_DATA) begin
			shadow_bank[shadow_sel] = it.data;
			return replay_map();
		end
		// any other low byte is dropped
		return 0;
	endfunction

	function automatic void apply_cfg(logic [1:0] idx, logic [7:0] val);
		case (idx)
			CFG_PROG_COUNT: begin
				prog_count = val;
			end
			CFG_CHAR_COUNT: begin
				char_count = val;
			end
			CFG_FOUR_SCREEN: begin
				four_scr = val[0];
			end
			default: begin
			end
		endcase
	endfunction

	initial begin
		for (int i = 0; i < 8; i++)
			shadow_bank[i] = 8'd0;
		shadow_sel = 3'd0;
		prog_count = 8'd0;
		char_count = 8'd0;
		four_scr = 1'b0;
	end

	// ------------------------------------------------------------------------
	// driver: plays bus_q out on the command and config channels
	// ------------------------------------------------------------------------

	bus_item_t   cur_cmd;
	bus_item_t   cur_cfg;
	int unsigned owed = 0;        // loads predicted but not yet strobed
	int unsigned settle = SETTLE_CYCLES;
	int unsigned gap_cnt = 0;

	always @(posedge clk) begin : driver
		logic nxt_start;
		logic nxt_cfg;
		bus_item_t head;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			nxt_start = start;
			nxt_cfg = cfg_valid;

			// results seen this edge pay back the outstanding count
			if (result_valid === 1'b1 && owed > 0)
				owed--;

			// command transaction taken at this edge
			if (start && !busy) begin
				owed += mapper_step(cur_cmd);
				nxt_start = 1'b0;
				settle = SETTLE_CYCLES;
			end

			// config transaction taken at this edge
			if (cfg_valid && cfg_ready) begin
				apply_cfg(cur_cfg.cfg_idx, cur_cfg.cfg_val);
				nxt_cfg = 1'b0;
				settle = SETTLE_CYCLES;
			end

			// quiet time since the last load and the end of busy
			if (owed == 0 && busy === 1'b0) begin
				if (settle > 0)
					settle--;
			end else begin
				settle = SETTLE_CYCLES;
			end

			if (!nxt_start && !nxt_cfg && bus_q.size() > 0) begin
				head = bus_q[0];
				case (head.what)
					ITEM_BUS: begin
						// idle burst in front of this command
						if (gap_cnt < head.gap) begin
							gap_cnt++;
						end else begin
							gap_cnt = 0;
							cur_cmd = bus_q.pop_front();
							mode <= cur_cmd.mode;
							address <= cur_cmd.address;
							data <= cur_cmd.data;
							nxt_start = 1'b1;
						end
					end
					ITEM_CFG: begin
						// registers change only once the block has gone quiet
						if (owed == 0 && settle == 0) begin
							cur_cfg = bus_q.pop_front();
							cfg_index <= cur_cfg.cfg_idx;
							cfg_data <= cur_cfg.cfg_val;
							nxt_cfg = 1'b1;
						end
					end
					default: begin
						// drain point: hold off until every load is in
						if (owed == 0 && settle == 0)
							void'(bus_q.pop_front());
					end
				endcase
			end

			start <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	// ------------------------------------------------------------------------
	// monitor: every strobed result against the oldest prediction
	// ------------------------------------------------------------------------

	always @(posedge clk) begin : monitor
		slot_load_t want;
		if (arst_n && result_valid !== 1'b0) begin
			if (load_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected load: kind=%0d slot=%0d bank=%0d last=%0d",
						kind, slot, bank, last);
			end else begin
				want = load_q.pop_front();
				if (kind !== want.kind || slot !== want.slot || bank !== want.bank ||
						last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"load mismatch: exp kind=%0d slot=%0d bank=%0d last=%0d,",
							" got kind=%0d slot=%0d bank=%0d last=%0d"},
							want.kind, want.slot, want.bank, want.last,
							kind, slot, bank, last);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	function automatic void add_bus(logic m, logic [15:0] a, logic [7:0] d);
		bus_item_t it;
		it = '0;
		it.what = ITEM_BUS;
		it.mode = m;
		it.address = a;
		it.data = d;
		it.gap = (idle_on != 0 && $urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 18)) : 5'd0;
		bus_q.push_back(it);
	endfunction

	function automatic void add_cfg(logic [1:0] idx, logic [7:0] val);
		bus_item_t it;
		it = '0;
		it.what = ITEM_CFG;
		it.cfg_idx = idx;
		it.cfg_val = val;
		bus_q.push_back(it);
	endfunction

	function automatic void add_pause();
		bus_item_t it;
		it = '0;
		it.what = ITEM_PAUSE;
		bus_q.push_back(it);
	endfunction

	// bank counts lean on the edges: 0, 1, 255 and small values
	function automatic logic [7:0] pick_count();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd255;
			3: return 8'($urandom_range(2, 9));
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	initial begin : stimulus
		int unsigned ph;
		int unsigned useful;
		int unsigned r;
		logic [7:0] lo;

		// directed part, counts still at reset: mirroring only
		add_bus(MODE_WRITE, 16'h0001, 8'hFF);
		add_cfg(CFG_PROG_COUNT, 8'd255);
		add_cfg(CFG_CHAR_COUNT, 8'd255);
		add_cfg(CFG_FOUR_SCREEN, 8'd0);
		// program register at its top value, high address byte set
		add_bus(MODE_WRITE, 16'hFF00, 8'h05);
		add_bus(MODE_WRITE, 16'hFF01, 8'hFF);
		// select taken from the low three data bits only
		add_bus(MODE_WRITE, 16'h0000, 8'hFC);
		add_bus(MODE_WRITE, 16'h0001, 8'h01);
		add_bus(MODE_WRITE, 16'h0000, 8'h00);
		add_bus(MODE_WRITE, 16'h8001, 8'hFF);
		// other low address bytes are dropped
		add_bus(MODE_WRITE, 16'h0002, 8'h55);
		add_bus(MODE_WRITE, 16'hFFFF, 8'hAA);
		add_bus(MODE_WRITE, 16'h00FE, 8'h01);
		// initialize ignores address and data
		add_bus(MODE_INIT, 16'hFFFF, 8'hFF);
		add_cfg(CFG_PROG_COUNT, 8'd1);
		add_cfg(CFG_CHAR_COUNT, 8'd1);
		add_cfg(CFG_FOUR_SCREEN, 8'd1);
		add_cfg(CFG_UNUSED, 8'hFF);
		add_bus(MODE_WRITE, 16'h0100, 8'h05);
		add_bus(MODE_WRITE, 16'h0001, 8'hAB);
		// registers six and seven are stored but never mapped
		add_bus(MODE_WRITE, 16'h0000, 8'h06);
		add_bus(MODE_WRITE, 16'h0001, 8'h77);
		add_bus(MODE_WRITE, 16'h0000, 8'h07);
		add_bus(MODE_WRITE, 16'h0001, 8'h80);
		// empty run: both groups off and four screens
		add_cfg(CFG_PROG_COUNT, 8'd0);
		add_cfg(CFG_CHAR_COUNT, 8'd0);
		add_bus(MODE_WRITE, 16'h0001, 8'h3C);
		add_bus(MODE_INIT, 16'h0000, 8'h00);

		// random part, one setting per phase
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					add_cfg(CFG_PROG_COUNT, 8'd255);
					add_cfg(CFG_CHAR_COUNT, 8'd255);
					add_cfg(CFG_FOUR_SCREEN, 8'd0);
				end
				1: begin
					add_cfg(CFG_PROG_COUNT, 8'd1);
					add_cfg(CFG_CHAR_COUNT, 8'd1);
					add_cfg(CFG_FOUR_SCREEN, 8'd1);
				end
				2: begin
					add_cfg(CFG_PROG_COUNT, 8'd0);
					add_cfg(CFG_CHAR_COUNT, 8'd0);
					add_cfg(CFG_FOUR_SCREEN, 8'd1);
				end
				default: begin
					add_cfg(CFG_PROG_COUNT, pick_count());
					add_cfg(CFG_CHAR_COUNT, pick_count());
					add_cfg(CFG_FOUR_SCREEN, {7'($urandom), 1'($urandom)});
				end
			endcase
			if ($urandom_range(0, 3) == 0)
				add_cfg(CFG_UNUSED, 8'($urandom));
			// every third phase runs back to back, the last one too
			idle_on = (ph % 3 == 2 || ph == 7) ? 0 : 1;
			useful = 0;
			while (useful < 50) begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					// well formed pair: select then data
					add_bus(MODE_WRITE, {8'($urandom), ADDR_SELECT}, 8'($urandom));
					add_bus(MODE_WRITE, {8'($urandom), ADDR_DATA}, 8'($urandom));
					useful += 2;
				end else if (r < 75) begin
					add_bus(MODE_INIT, 16'($urandom), 8'($urandom));
					useful++;
				end else if (r < 87) begin
					add_bus(MODE_WRITE, {8'($urandom), ADDR_DATA}, 8'($urandom));
					useful++;
				end else begin
					// noise on the low address byte
					lo = 8'($urandom);
					add_bus(MODE_WRITE, {8'($urandom), lo}, 8'($urandom));
					if (lo == ADDR_SELECT || lo == ADDR_DATA)
						useful++;
				end
			end
			if (ph == 3 || ph == 5)
				add_pause();
		end

		// hold reset, then release on a clock edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the queue to play out and every load to arrive
		@(negedge clk);
		while (bus_q.size() != 0 || start || cfg_valid)
			@(negedge clk);
		while (load_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatches == 0 && load_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			if (load_q.size() != 0)
				$display("%0d predicted loads never arrived", load_q.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout waiting for the mapper");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
hdl/cbm_pkg.sv
hdl/cartridge_bank_mapper.sv
hdl/cbm_checker.sv
tb/testbench.sv
